// ===== src/dft7w_pkg.sv =====
// Shared types, constants and coefficient table for the 7-point DFT unit.
package dft7w_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int BLOCK_LEN    = 7;
    localparam int NUM_COEF     = 8;
    localparam int COEF_W       = 18;
    localparam int FRAC_W       = 16;
    localparam int MUL_W        = SAMPLE_WIDTH + 3;
    localparam int PROD_W       = MUL_W + COEF_W;
    localparam int RND_W        = PROD_W - FRAC_W;
    localparam int OUT_W        = 20;
    localparam int ACC_W        = (SAMPLE_WIDTH + 8 > OUT_W + 1) ? SAMPLE_WIDTH + 8 : OUT_W + 1;
    localparam int QUEUE_DEPTH  = 2;  // power of two
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] LAST_IDX = 3'(BLOCK_LEN - 1);
    localparam logic [2:0] HALF_IDX = 3'(BLOCK_LEN / 2);

    // Q2.16 coefficients
    localparam logic signed [COEF_W-1:0] Q_CX0 = COEF_W'(-10923);
    localparam logic signed [COEF_W-1:0] Q_CX1 = COEF_W'(99907);
    localparam logic signed [COEF_W-1:0] Q_CX2 = COEF_W'(44463);
    localparam logic signed [COEF_W-1:0] Q_CX3 = COEF_W'(48123);
    localparam logic signed [COEF_W-1:0] Q_SX0 = COEF_W'(28899);
    localparam logic signed [COEF_W-1:0] Q_SX1 = COEF_W'(79673);
    localparam logic signed [COEF_W-1:0] Q_SX2 = COEF_W'(92328);
    localparam logic signed [COEF_W-1:0] Q_SX3 = COEF_W'(57334);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_samp;
    typedef logic signed [OUT_W-1:0]        t_bin;

    typedef struct packed {
        t_samp [BLOCK_LEN-1:0] re;
        t_samp [BLOCK_LEN-1:0] im;
    } t_block;

    // coefficient for each operand slot of one path
    function automatic logic signed [COEF_W-1:0] coef(input logic [2:0] slot);
        logic signed [COEF_W-1:0] c;
        case (slot)
            3'd0:    c = Q_CX0;
            3'd1:    c = Q_CX3;
            3'd2:    c = Q_CX1;
            3'd3:    c = Q_CX2;
            3'd4:    c = Q_SX0;
            3'd5:    c = Q_SX3;
            3'd6:    c = Q_SX1;
            3'd7:    c = Q_SX2;
            default: c = Q_CX0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/dft7w_front.sv =====
// Input side: collects samples and hands complete seven-sample blocks to the queue.
module dft7w_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dft7w_pkg::t_samp     i_sample_re,
    input  dft7w_pkg::t_samp     i_sample_im,
    input  logic                 i_q_full,
    output logic                 o_push,
    output dft7w_pkg::t_block    o_blk
);
    import dft7w_pkg::*;

    t_samp       r_re [BLOCK_LEN-1];
    t_samp       r_im [BLOCK_LEN-1];
    logic [2:0]  r_fill;
    logic [2:0]  n_fill;
    logic        accept;

    assign o_in_ready = !((r_fill == LAST_IDX) && i_q_full);
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (r_fill == LAST_IDX);

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            n_fill = (r_fill == LAST_IDX) ? 3'd0 : r_fill + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_fill != LAST_IDX)) begin
            r_re[r_fill] <= i_sample_re;
            r_im[r_fill] <= i_sample_im;
        end
    end

    always_comb begin
        for (int i = 0; i < BLOCK_LEN - 1; i++) begin
            o_blk.re[i] = r_re[i];
            o_blk.im[i] = r_im[i];
        end
        o_blk.re[BLOCK_LEN-1] = i_sample_re;
        o_blk.im[BLOCK_LEN-1] = i_sample_im;
    end

endmodule

// ===== src/dft7w_queue.sv =====
// Short block queue between the sample collector and the transform engine.
module dft7w_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dft7w_pkg::t_block    i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output dft7w_pkg::t_block    o_data
);
    import dft7w_pkg::*;

    t_block                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/dft7w_back.sv =====
// Transform engine: Winograd 7-point DFT on one shared multiplier, bins out in order.
module dft7w_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  dft7w_pkg::t_block    i_q_data,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dft7w_pkg::t_bin      o_bin_re,
    output dft7w_pkg::t_bin      o_bin_im,
    output logic [2:0]           o_bin_index,
    output logic                 o_last_bin
);
    import dft7w_pkg::*;

    localparam int              N_PROD   = 2 * NUM_COEF;
    localparam int              CNT_W    = $clog2(N_PROD);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_PROD - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_RND  = 5'b00100,
        S_COMB = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           r_pidx;
    logic                       r_pv;
    logic [2:0]                 r_k;
    logic                       r_ov;
    logic                       load;

    logic signed [MUL_W-1:0]    r_ops [2][NUM_COEF];
    logic signed [MUL_W-1:0]    n_ops [2][NUM_COEF];
    logic signed [ACC_W-1:0]    r_x0  [2];
    logic signed [ACC_W-1:0]    n_x0  [2];
    logic signed [ACC_W-1:0]    r_dc  [2];
    logic signed [ACC_W-1:0]    n_dc  [2];
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   rnd_sum;
    logic signed [RND_W-1:0]    r_res [2][NUM_COEF];
    logic signed [ACC_W-1:0]    r_cs  [2][3];
    logic signed [ACC_W-1:0]    r_sn  [2][3];
    logic signed [ACC_W-1:0]    n_cs  [2][3];
    logic signed [ACC_W-1:0]    n_sn  [2][3];
    logic signed [ACC_W-1:0]    bin_re;
    logic signed [ACC_W-1:0]    bin_im;
    logic [1:0]                 sel;

    t_bin                       r_bin_re;
    t_bin                       r_bin_im;
    logic [2:0]                 r_bin_index;
    logic                       r_last_bin;

    function automatic t_bin sat(input logic signed [ACC_W-1:0] v);
        t_bin s;
        if (v > ACC_W'(2 ** (OUT_W - 1) - 1)) begin
            s = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (v < -(ACC_W'(2 ** (OUT_W - 1)))) begin
            s = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            s = v[OUT_W-1:0];
        end
        return s;
    endfunction

    // symmetric sums and differences, both paths
    always_comb begin
        logic signed [MUL_W-1:0] x [BLOCK_LEN];
        logic signed [MUL_W-1:0] p1, p2, p3, m1, m2, m3, tot, u, v, d, f;
        for (int p = 0; p < 2; p++) begin
            for (int i = 0; i < BLOCK_LEN; i++) begin
                x[i] = (p == 0) ? MUL_W'($signed(i_q_data.re[i]))
                                : MUL_W'($signed(i_q_data.im[i]));
            end
            p1  = x[1] + x[6];
            p2  = x[2] + x[5];
            p3  = x[3] + x[4];
            m1  = x[1] - x[6];
            m2  = x[2] - x[5];
            m3  = x[3] - x[4];
            tot = p1 + p2 + p3;
            u   = p1 - p2;
            v   = p3 - p2;
            d   = m1 - m2;
            f   = m3 + m2;
            n_ops[p][0] = tot;
            n_ops[p][1] = u + v;
            n_ops[p][2] = u;
            n_ops[p][3] = v;
            n_ops[p][4] = m1 - m3 + m2;
            n_ops[p][5] = f - d;
            n_ops[p][6] = d;
            n_ops[p][7] = f;
            n_x0[p]     = ACC_W'(x[0]);
            n_dc[p]     = ACC_W'(tot) + ACC_W'(x[0]);
        end
    end

    // cosine and sine parts from the rounded products
    always_comb begin
        logic signed [ACC_W-1:0] rs [NUM_COEF];
        logic signed [ACC_W-1:0] base, ru, rv, dd, ff;
        for (int p = 0; p < 2; p++) begin
            for (int c = 0; c < NUM_COEF; c++) begin
                rs[c] = ACC_W'(r_res[p][c]);
            end
            base = rs[0] + r_x0[p];
            ru   = rs[2] - rs[1];
            rv   = rs[3] - rs[1];
            n_cs[p][0] = base + ru;
            n_cs[p][1] = base - ru - rv;
            n_cs[p][2] = base + rv;
            dd   = rs[5] + rs[6];
            ff   = rs[5] - rs[7];
            n_sn[p][0] = rs[4] + dd;
            n_sn[p][1] = rs[4] - dd - ff;
            n_sn[p][2] = -(rs[4] + ff);
        end
    end

    // bin k pairs with bin 7-k
    always_comb begin
        sel = (r_k <= HALF_IDX) ? 2'(r_k - 3'd1) : 2'(LAST_IDX - r_k);
        if (r_k == 3'd0) begin
            bin_re = r_dc[0];
            bin_im = r_dc[1];
        end else if (r_k <= HALF_IDX) begin
            bin_re = r_cs[0][sel] + r_sn[1][sel];
            bin_im = r_cs[1][sel] - r_sn[0][sel];
        end else begin
            bin_re = r_cs[0][sel] - r_sn[1][sel];
            bin_im = r_cs[1][sel] + r_sn[0][sel];
        end
    end

    assign load    = (r_state == S_OUT) && (!r_ov || i_out_ready);
    assign rnd_sum = r_prod + PROD_W'(2 ** (FRAC_W - 1));

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_RND;
                end
            end
            S_RND:  n_state = S_COMB;
            S_COMB: n_state = S_OUT;
            S_OUT: begin
                if (load && (r_k == LAST_IDX)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_k     <= 3'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_MUL);
            if (r_state == S_IDLE) begin
                r_cnt <= '0;
                r_k   <= 3'd0;
            end else if (r_state == S_MUL) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (load) begin
                r_k  <= r_k + 3'd1;
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ops <= n_ops;
            r_x0  <= n_x0;
            r_dc  <= n_dc;
        end
        r_prod <= r_ops[r_cnt[CNT_W-1]][r_cnt[CNT_W-2:0]] * coef(r_cnt[CNT_W-2:0]);
        r_pidx <= r_cnt;
        if (r_pv) begin
            r_res[r_pidx[CNT_W-1]][r_pidx[CNT_W-2:0]] <= rnd_sum[PROD_W-1:FRAC_W];
        end
        if (r_state == S_COMB) begin
            r_cs <= n_cs;
            r_sn <= n_sn;
        end
        if (load) begin
            r_bin_re    <= sat(bin_re);
            r_bin_im    <= sat(bin_im);
            r_bin_index <= r_k;
            r_last_bin  <= (r_k == LAST_IDX);
        end
    end

    assign o_out_valid = r_ov;
    assign o_bin_re    = r_bin_re;
    assign o_bin_im    = r_bin_im;
    assign o_bin_index = r_bin_index;
    assign o_last_bin  = r_last_bin;

`ifndef ASSERT_OFF
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) && (r_cnt == CNT_LAST) |=> (r_state == S_RND))
        else $error("multiply sweep did not end after the last product");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_MUL) && (r_cnt == '0))
        else $error("block popped without a fresh multiply sweep");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bin_index <= LAST_IDX))
        else $error("bin index out of range");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_bin == (o_bin_index == LAST_IDX)))
        else $error("last mark not on final bin");
`endif

endmodule

// ===== src/dft7_winograd_unit.sv =====
// Top level of the streaming 7-point Winograd DFT unit.
//
// Input channel (i_in_valid / o_in_ready): one complex sample per beat,
// i_sample_re and i_sample_im, two's complement. Every seven beats form
// one block, sample 0 first.
// Output channel (o_out_valid / i_out_ready): seven beats per block, bins
// 0 to 6 in order, with o_bin_index and o_last_bin high on bin 6.
// The engine loads a block from the queue, runs sixteen products on the
// single shared multiplier (one per cycle), then rounding, combine and
// seven output beats, and takes the next block only after the last bin
// has been loaded into its output register.
// A two-block queue sits between collector and engine, so samples keep
// flowing while a transform runs. If the receiver stalls, the engine holds
// its output register, the queue fills, and o_in_ready drops only on the
// beat that would complete a block with no queue space left.
// Reset (i_rst_n low, synchronous) empties the queue, clears the sample
// count and drops o_out_valid; partial blocks are discarded.
module dft7_winograd_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dft7w_pkg::t_samp     i_sample_re,
    input  dft7w_pkg::t_samp     i_sample_im,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dft7w_pkg::t_bin      o_bin_re,
    output dft7w_pkg::t_bin      o_bin_im,
    output logic [2:0]           o_bin_index,
    output logic                 o_last_bin
);
    import dft7w_pkg::*;

    logic    push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_block  push_blk;
    t_block  q_blk;

    dft7w_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_blk       (push_blk)
    );

    dft7w_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_blk),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_blk)
    );

    dft7w_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_blk),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_bin_index (o_bin_index),
        .o_last_bin  (o_last_bin)
    );

endmodule

// ===== sim/dft7_winograd_unit_tb.sv =====
// Self-checking testbench for the streaming 7-point Winograd DFT unit.
module dft7_winograd_unit_tb;

    import dft7w_pkg::*;

    localparam int     BINS     = 7;
    localparam int     N_BLOCKS = 30;
    localparam int     MAXV     = 32767;
    localparam int     MINV     = -32768;
    localparam longint BIN_MAX  = 524287;
    localparam longint BIN_MIN  = -524288;

    // Q2.16 twiddle terms
    localparam longint C_CX0 = -10923;
    localparam longint C_CX1 = 99907;
    localparam longint C_CX2 = 44463;
    localparam longint C_CX3 = 48123;
    localparam longint C_SX0 = 28899;
    localparam longint C_SX1 = 79673;
    localparam longint C_SX2 = 92328;
    localparam longint C_SX3 = 57334;

    typedef struct packed {
        t_bin       re;
        t_bin       im;
        logic [2:0] idx;
        logic       last;
    } t_bin_beat;

    typedef struct packed {
        longint dc;
        longint c1, c2, c3;
        longint s1, s2, s3;
    } t_path;

    class dft7_bins_sb;
        longint    held_re[BINS];
        longint    held_im[BINS];
        int        fill;
        int        errors;
        t_bin_beat bins_due[$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function longint qround(longint x, longint c);
            return (x * c + 32768) >>> 16;
        endfunction

        function t_bin sat20(longint v);
            if (v > BIN_MAX) return t_bin'(BIN_MAX);
            if (v < BIN_MIN) return t_bin'(BIN_MIN);
            return t_bin'(v);
        endfunction

        function t_path fold_path(bit im_part);
            longint x[BINS];
            longint p1, p2, p3, m1, m2, m3, total, base, u, v, w, ru, rv;
            longint e, d, f, g, dd, ff;
            t_path  r;
            for (int i = 0; i < BINS; i++) x[i] = im_part ? held_im[i] : held_re[i];
            p1 = x[1] + x[6];
            p2 = x[2] + x[5];
            p3 = x[3] + x[4];
            m1 = x[1] - x[6];
            m2 = x[2] - x[5];
            m3 = x[3] - x[4];
            total = p1 + p2 + p3;
            r.dc  = total + x[0];
            base  = qround(total, C_CX0) + x[0];
            u     = p1 - p2;
            v     = p3 - p2;
            w     = qround(u + v, C_CX3);
            ru    = qround(u, C_CX1) - w;
            rv    = qround(v, C_CX2) - w;
            r.c1  = base + ru;
            r.c2  = base - ru - rv;
            r.c3  = base + rv;
            e     = qround(m1 - m3 + m2, C_SX0);
            d     = m1 - m2;
            f     = m3 + m2;
            g     = qround(f - d, C_SX3);
            dd    = g + qround(d, C_SX1);
            ff    = g - qround(f, C_SX2);
            r.s1  = e + dd;
            r.s2  = e - dd - ff;
            r.s3  = -(e + ff);
            return r;
        endfunction

        function void transform_block();
            t_path     pr, pi;
            longint    br[BINS];
            longint    bi[BINS];
            t_bin_beat b;
            pr = fold_path(1'b0);
            pi = fold_path(1'b1);
            br[0] = pr.dc;          bi[0] = pi.dc;
            br[1] = pr.c1 + pi.s1;  bi[1] = pi.c1 - pr.s1;
            br[6] = pr.c1 - pi.s1;  bi[6] = pi.c1 + pr.s1;
            br[2] = pr.c2 + pi.s2;  bi[2] = pi.c2 - pr.s2;
            br[5] = pr.c2 - pi.s2;  bi[5] = pi.c2 + pr.s2;
            br[3] = pr.c3 + pi.s3;  bi[3] = pi.c3 - pr.s3;
            br[4] = pr.c3 - pi.s3;  bi[4] = pi.c3 + pr.s3;
            for (int k = 0; k < BINS; k++) begin
                b.re   = sat20(br[k]);
                b.im   = sat20(bi[k]);
                b.idx  = 3'(k);
                b.last = (k == BINS - 1);
                bins_due.push_back(b);
            end
        endfunction

        function void note_sample(t_samp re, t_samp im);
            held_re[fill] = re;
            held_im[fill] = im;
            fill++;
            if (fill == BINS) begin
                fill = 0;
                transform_block();
            end
        endfunction

        function void check_bin(t_bin re, t_bin im, logic [2:0] idx, logic last);
            t_bin_beat b;
            if (bins_due.size() == 0) begin
                $error("unexpected bin beat: re=%0d im=%0d idx=%0d", re, im, idx);
                errors++;
                return;
            end
            b = bins_due.pop_front();
            if (re !== b.re) begin
                $error("bin_re: expected %0d, got %0d", b.re, re);
                errors++;
            end
            if (im !== b.im) begin
                $error("bin_im: expected %0d, got %0d", b.im, im);
                errors++;
            end
            if (idx !== b.idx) begin
                $error("bin_index: expected %0d, got %0d", b.idx, idx);
                errors++;
            end
            if (last !== b.last) begin
                $error("last_bin: expected %0b, got %0b", b.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return bins_due.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_samp      i_sample_re;
    t_samp      i_sample_im;
    logic       o_out_valid;
    logic       i_out_ready;
    t_bin       o_bin_re;
    t_bin       o_bin_im;
    logic [2:0] o_bin_index;
    logic       o_last_bin;

    dft7_bins_sb sb = new();
    bit          calm;

    dft7_winograd_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_bin_index (o_bin_index),
        .o_last_bin  (o_last_bin)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_sample(input t_samp re, input t_samp im);
        if (!calm) begin
            while ($urandom_range(99) < 15) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(re, im);
    endtask

    function automatic t_samp rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return t_samp'($urandom);
        if (pick < 80) return t_samp'(int'($urandom_range(64)) - 32);
        case ($urandom_range(3))
            0:       return t_samp'(MAXV);
            1:       return t_samp'(MINV);
            2:       return t_samp'(0);
            default: return t_samp'(-1);
        endcase
    endfunction

    // bin sink: random backpressure outside the calm blocks, check every accepted beat
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_bin(o_bin_re, o_bin_im, o_bin_index, o_last_bin);
            i_out_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    initial begin
        calm = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample_re <= '0;
        i_sample_im <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale DC
        for (int n = 0; n < BINS; n++) send_sample(t_samp'(MAXV), t_samp'(MINV));
        // alternating extremes
        for (int n = 0; n < BINS; n++) begin
            if (n % 2 == 0) send_sample(t_samp'(MAXV), t_samp'(MINV));
            else            send_sample(t_samp'(MINV), t_samp'(MAXV));
        end
        // impulses at sample 0 and sample 3
        for (int n = 0; n < BINS; n++) begin
            if (n == 0)      send_sample(t_samp'(MINV), t_samp'(MAXV));
            else if (n == 3) send_sample(t_samp'(-1), t_samp'(1));
            else             send_sample(t_samp'(0), t_samp'(0));
        end

        for (int blk = 0; blk < N_BLOCKS; blk++) begin
            calm = (blk >= 12 && blk < 20);
            for (int n = 0; n < BINS; n++) send_sample(rand_sample(), rand_sample());
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
